// ----- src/wss_pkg.sv -----
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, codes and widths of the wind sample statistics unit.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned SAMPLE_DEPTH_DEF       = 1024;
  localparam int unsigned NUM_PERIODS_DEF        = 4;
  localparam int unsigned SAMPLES_PER_PERIOD_DEF = 256;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PERIOD_W = 2;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SPEED_W  = 32;

  localparam int unsigned SUM_W    = SAMPLE_W + LEN_W;         // window sum
  localparam int unsigned DVD_W    = SUM_W + 8;                // sum in Q.8
  localparam int unsigned SQR_W    = 2 * MEAN_W;               // one squared deviation
  localparam int unsigned SQ_W     = SQR_W + LEN_W;            // sum of squares
  localparam int unsigned RAD_W    = SQ_W + (SQ_W % 2);        // radicand, even width
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned PROD_W   = ROOT_W + SCALE_W;

  localparam logic [15:0] EMPTY_MIN   = 16'hFFFF;
  localparam logic [23:0] SCALE_RESET = 24'd65536;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_EXTR  = 2'd2,
    OP_STATS = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_WIN  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
    logic [PERIOD_W-1:0] period;
    logic [LEN_W-1:0]    offset;
    logic [LEN_W-1:0]    length;
    logic                use_given_mean;
    logic [MEAN_W-1:0]   given_mean;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SAMPLE_W-1:0] max_value;
    logic [SAMPLE_W-1:0] min_value;
    logic [SPEED_W-1:0]  mean_speed;
    logic [SPEED_W-1:0]  std_speed;
  } res_t;

  typedef struct packed {
    logic load;
    logic simple;
    logic set_bad;
    logic walk_start;
    logic walk_run;
    logic walk_sq;
    logic div_mean_start;
    logic div_var_start;
    logic div_run;
    logic mean_take;
    logic sqrt_start;
    logic sqrt_run;
    logic spd_mean;
    logic spd_std;
    logic spd_done;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic is_stats;
    logic win_bad;
    logic walk_done;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } sts_t;

endpackage

// ----- src/wss_if.sv -----
// ----------------------------------------------------------------------------
// wss_in_if / wss_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface wss_in_if;
  logic                           valid;
  logic                           ready;
  logic [wss_pkg::OP_W-1:0]       op;
  logic [wss_pkg::SAMPLE_W-1:0]   sample;
  logic [wss_pkg::PERIOD_W-1:0]   period;
  logic [wss_pkg::LEN_W-1:0]      offset;
  logic [wss_pkg::LEN_W-1:0]      length;
  logic                           use_given_mean;
  logic [wss_pkg::MEAN_W-1:0]     given_mean;

  modport source (output valid, op, sample, period, offset, length, use_given_mean,
                  given_mean, input ready);
  modport sink (input valid, op, sample, period, offset, length, use_given_mean,
                given_mean, output ready);
endinterface

interface wss_out_if;
  logic                           valid;
  logic                           ready;
  logic [wss_pkg::STATUS_W-1:0]   status;
  logic [wss_pkg::SAMPLE_W-1:0]   max_value;
  logic [wss_pkg::SAMPLE_W-1:0]   min_value;
  logic [wss_pkg::SPEED_W-1:0]    mean_speed;
  logic [wss_pkg::SPEED_W-1:0]    std_speed;

  modport source (output valid, status, max_value, min_value, mean_speed, std_speed,
                  input ready);
  modport sink (input valid, status, max_value, min_value, mean_speed, std_speed,
                output ready);
endinterface

// ----- src/wss_ctrl.sv -----
// ----------------------------------------------------------------------------
// wss_ctrl
// Sequencer: walks a request through the datapath phases.
// ----------------------------------------------------------------------------
module wss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wss_pkg::sts_t sts_i,
  output wss_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SUM, S_DIV_MEAN, S_SQ, S_DIV_VAR, S_SQRT,
    S_SPD0, S_SPD1, S_SPD2, S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.is_stats) begin
          cmd_o.simple = 1'b1;
          state_d      = S_FINISH;
        end else if (sts_i.win_bad) begin
          cmd_o.set_bad = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_SUM;
        end
      end
      S_SUM: begin
        if (sts_i.walk_done) begin
          cmd_o.div_mean_start = 1'b1;
          state_d              = S_DIV_MEAN;
        end else begin
          cmd_o.walk_run = 1'b1;
        end
      end
      S_DIV_MEAN: begin
        if (sts_i.div_done) begin
          cmd_o.mean_take  = 1'b1;
          cmd_o.walk_start = 1'b1;
          state_d          = S_SQ;
        end else begin
          cmd_o.div_run = 1'b1;
        end
      end
      S_SQ: begin
        if (sts_i.walk_done) begin
          cmd_o.div_var_start = 1'b1;
          state_d             = S_DIV_VAR;
        end else begin
          cmd_o.walk_run = 1'b1;
          cmd_o.walk_sq  = 1'b1;
        end
      end
      S_DIV_VAR: begin
        if (sts_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SQRT;
        end else begin
          cmd_o.div_run = 1'b1;
        end
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          state_d = S_SPD0;
        end else begin
          cmd_o.sqrt_run = 1'b1;
        end
      end
      S_SPD0: begin
        cmd_o.spd_mean = 1'b1;
        state_d        = S_SPD1;
      end
      S_SPD1: begin
        cmd_o.spd_std = 1'b1;
        state_d       = S_SPD2;
      end
      S_SPD2: begin
        cmd_o.spd_done = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/wss_datapath.sv -----
// ----------------------------------------------------------------------------
// wss_datapath
// Sample memory, period extremes, window walk, divider, root and scaling.
// ----------------------------------------------------------------------------
module wss_datapath #(
  parameter int unsigned SAMPLE_DEPTH       = wss_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned NUM_PERIODS        = wss_pkg::NUM_PERIODS_DEF,
  parameter int unsigned SAMPLES_PER_PERIOD = wss_pkg::SAMPLES_PER_PERIOD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wss_pkg::cmd_t                 cmd_i,
  output wss_pkg::sts_t                 sts_o,
  input  wss_pkg::req_t                 req_i,
  input  logic [wss_pkg::SCALE_W-1:0]   speed_scale_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wss_pkg::res_t                 out_res_o
);

  localparam int unsigned ADDR_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned IDX_W   = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned PIDX_W  = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;
  localparam int unsigned PER_W   = IDX_W + PIDX_W;
  localparam int unsigned CNT_W   = (SAMPLES_PER_PERIOD > 1) ? $clog2(SAMPLES_PER_PERIOD) : 1;
  localparam int unsigned DCNT_W  = $clog2(wss_pkg::SQ_W + 1);
  localparam int unsigned RCNT_W  = $clog2(wss_pkg::ROOT_W + 1);
  localparam int unsigned REM_W   = wss_pkg::ROOT_W + 2;
  localparam int unsigned RND_W   = wss_pkg::PROD_W + 1;

  function automatic logic [wss_pkg::SPEED_W-1:0] sat_speed(
    input logic [wss_pkg::PROD_W-1:0] p
  );
    logic [RND_W-1:0] rnd;
    rnd = RND_W'(p) + RND_W'(32768);
    if (|rnd[RND_W-1:16+wss_pkg::SPEED_W]) begin
      return '1;
    end
    return rnd[16+wss_pkg::SPEED_W-1:16];
  endfunction

  // latched request
  wss_pkg::req_t req_q;

  // store and extremes
  logic [wss_pkg::SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic [IDX_W-1:0]             wr_idx_q;
  logic [PER_W-1:0]             per_q;
  logic [CNT_W-1:0]             per_cnt_q;
  logic [wss_pkg::SAMPLE_W-1:0] pmax_q [NUM_PERIODS];
  logic [wss_pkg::SAMPLE_W-1:0] pmin_q [NUM_PERIODS];

  // walk pipeline
  logic [wss_pkg::LEN_W-1:0]    rd_cnt_q;
  logic                         rd_vld_q, rd_hit_q;
  logic [wss_pkg::SAMPLE_W-1:0] rdata_q;
  logic                         d_vld_q, s_vld_q;
  logic [wss_pkg::MEAN_W-1:0]   d_q;
  logic [wss_pkg::SQR_W-1:0]    s_q;
  logic [wss_pkg::SUM_W-1:0]    sum_q;
  logic [wss_pkg::SQ_W-1:0]     sq_q;

  // divider, root, scaling
  logic [wss_pkg::SQ_W-1:0]     n_q;
  logic [wss_pkg::LEN_W:0]      r_q;
  logic [DCNT_W-1:0]            dcnt_q;
  logic [wss_pkg::MEAN_W-1:0]   mean_q;
  logic [wss_pkg::RAD_W-1:0]    v_q;
  logic [REM_W-1:0]             rem_q;
  logic [wss_pkg::ROOT_W-1:0]   root_q;
  logic [RCNT_W-1:0]            rcnt_q;
  logic [wss_pkg::PROD_W-1:0]   prod_q;

  wss_pkg::res_t res_q;
  wss_pkg::res_t out_q;
  logic          out_vld_q;

  // combinational helpers
  logic                         full, push_we, per_in, qper_in;
  logic [PER_W-1:0]             qper;
  logic [PIDX_W-1:0]            wp, qp;
  logic                         issue;
  logic [31:0]                  raddr;
  logic [wss_pkg::SAMPLE_W-1:0] smp;
  logic [wss_pkg::MEAN_W-1:0]   x, m;
  logic [wss_pkg::LEN_W+1:0]    rs;
  logic [wss_pkg::DVD_W-1:0]    dvd;
  logic [REM_W+1:0]             rrs, trial;

  assign full    = (wr_idx_q == IDX_W'(SAMPLE_DEPTH));
  assign push_we = cmd_i.simple && (req_q.op == wss_pkg::OP_PUSH) && !full;
  assign per_in  = (32'(per_q) < 32'(NUM_PERIODS));
  assign wp      = per_q[PIDX_W-1:0];
  assign qper    = PER_W'(req_q.period);
  assign qp      = qper[PIDX_W-1:0];
  assign qper_in = (32'(req_q.period) < 32'(NUM_PERIODS));

  assign issue = (rd_cnt_q != req_q.length);
  assign raddr = 32'(req_q.offset) + 32'(rd_cnt_q);
  assign smp   = rd_hit_q ? rdata_q : '0;
  assign x     = {smp, 8'b0};
  assign m     = req_q.use_given_mean ? req_q.given_mean : mean_q;

  assign rs  = {r_q, n_q[wss_pkg::SQ_W-1]};
  assign dvd = {sum_q, 8'b0} + wss_pkg::DVD_W'(req_q.length >> 1);

  assign rrs   = {rem_q, v_q[wss_pkg::RAD_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_q, 2'b01});

  always_comb begin
    sts_o           = '0;
    sts_o.is_stats  = (req_q.op == wss_pkg::OP_STATS);
    sts_o.win_bad   = (req_q.length == '0) ||
                      (32'(req_q.offset) + 32'(req_q.length) > 32'(SAMPLE_DEPTH));
    sts_o.walk_done = !issue && !rd_vld_q && !d_vld_q && !s_vld_q;
    sts_o.div_done  = (dcnt_q == '0);
    sts_o.sqrt_done = (rcnt_q == '0);
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push_we) begin
      mem[wr_idx_q[ADDR_W-1:0]] <= req_q.sample;
    end
    rdata_q <= mem[raddr[ADDR_W-1:0]];
  end

  // fill count and period extremes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      per_q     <= '0;
      per_cnt_q <= '0;
      for (int i = 0; i < NUM_PERIODS; i++) begin
        pmax_q[i] <= '0;
        pmin_q[i] <= wss_pkg::EMPTY_MIN;
      end
    end else if (cmd_i.simple && req_q.op == wss_pkg::OP_CLEAR) begin
      wr_idx_q  <= '0;
      per_q     <= '0;
      per_cnt_q <= '0;
      for (int i = 0; i < NUM_PERIODS; i++) begin
        pmax_q[i] <= '0;
        pmin_q[i] <= wss_pkg::EMPTY_MIN;
      end
    end else if (push_we) begin
      wr_idx_q <= wr_idx_q + 1'b1;
      if (per_cnt_q == CNT_W'(SAMPLES_PER_PERIOD - 1)) begin
        per_cnt_q <= '0;
        per_q     <= per_q + 1'b1;
      end else begin
        per_cnt_q <= per_cnt_q + 1'b1;
      end
      if (per_in) begin
        if (req_q.sample > pmax_q[wp]) pmax_q[wp] <= req_q.sample;
        if (req_q.sample < pmin_q[wp]) pmin_q[wp] <= req_q.sample;
      end
    end
  end

  // walk control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
      d_vld_q  <= 1'b0;
      s_vld_q  <= 1'b0;
      dcnt_q   <= '0;
      rcnt_q   <= '0;
    end else begin
      if (cmd_i.walk_start) begin
        rd_cnt_q <= '0;
        rd_vld_q <= 1'b0;
        d_vld_q  <= 1'b0;
        s_vld_q  <= 1'b0;
      end else if (cmd_i.walk_run) begin
        if (issue) rd_cnt_q <= rd_cnt_q + 1'b1;
        rd_vld_q <= issue;
        d_vld_q  <= rd_vld_q && cmd_i.walk_sq;
        s_vld_q  <= d_vld_q;
      end
      if (cmd_i.div_mean_start || cmd_i.div_var_start) begin
        dcnt_q <= DCNT_W'(wss_pkg::SQ_W);
      end else if (cmd_i.div_run) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.sqrt_start) begin
        rcnt_q <= RCNT_W'(wss_pkg::ROOT_W);
      end else if (cmd_i.sqrt_run) begin
        rcnt_q <= rcnt_q - 1'b1;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;

    if (cmd_i.walk_start) begin
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.walk_run) begin
      if (rd_vld_q && !cmd_i.walk_sq) sum_q <= sum_q + wss_pkg::SUM_W'(smp);
      rd_hit_q <= raddr < 32'(wr_idx_q);
      d_q      <= (x >= m) ? x - m : m - x;
      s_q      <= wss_pkg::SQR_W'(d_q) * wss_pkg::SQR_W'(d_q);
      if (s_vld_q) sq_q <= sq_q + wss_pkg::SQ_W'(s_q);
    end

    // restoring divider by the window length, one quotient bit a cycle
    if (cmd_i.div_mean_start) begin
      n_q <= wss_pkg::SQ_W'(dvd);
      r_q <= '0;
    end else if (cmd_i.div_var_start) begin
      n_q <= sq_q;
      r_q <= '0;
    end else if (cmd_i.div_run) begin
      if (rs >= (wss_pkg::LEN_W + 2)'(req_q.length)) begin
        r_q <= (wss_pkg::LEN_W + 1)'(rs - (wss_pkg::LEN_W + 2)'(req_q.length));
        n_q <= {n_q[wss_pkg::SQ_W-2:0], 1'b1};
      end else begin
        r_q <= rs[wss_pkg::LEN_W:0];
        n_q <= {n_q[wss_pkg::SQ_W-2:0], 1'b0};
      end
    end
    if (cmd_i.mean_take) mean_q <= n_q[wss_pkg::MEAN_W-1:0];

    // digit-by-digit square root, two radicand bits a cycle
    if (cmd_i.sqrt_start) begin
      v_q    <= wss_pkg::RAD_W'(n_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_run) begin
      v_q <= {v_q[wss_pkg::RAD_W-3:0], 2'b00};
      if (rrs >= trial) begin
        rem_q  <= REM_W'(rrs - trial);
        root_q <= {root_q[wss_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= REM_W'(rrs);
        root_q <= {root_q[wss_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    // speed scaling: multiply, register, then round and saturate
    if (cmd_i.spd_mean) begin
      prod_q <= wss_pkg::PROD_W'(mean_q) * wss_pkg::PROD_W'(speed_scale_i);
    end else if (cmd_i.spd_std) begin
      prod_q <= wss_pkg::PROD_W'(root_q) * wss_pkg::PROD_W'(speed_scale_i);
    end

    // staged result
    if (cmd_i.simple) begin
      res_q <= '0;
      unique case (wss_pkg::op_e'(req_q.op))
        wss_pkg::OP_PUSH: begin
          if (full) res_q.status <= wss_pkg::ST_FULL;
        end
        wss_pkg::OP_EXTR: begin
          if (qper_in) begin
            res_q.max_value <= pmax_q[qp];
            res_q.min_value <= pmin_q[qp];
          end else begin
            res_q.min_value <= wss_pkg::EMPTY_MIN;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.set_bad) begin
      res_q        <= '0;
      res_q.status <= wss_pkg::ST_WIN;
    end else if (cmd_i.walk_start && !cmd_i.mean_take) begin
      res_q <= '0;
    end else if (cmd_i.spd_std) begin
      res_q.mean_speed <= sat_speed(prod_q);
    end else if (cmd_i.spd_done) begin
      res_q.std_speed <= sat_speed(prod_q);
    end

    if (cmd_i.publish) out_q <= res_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

// ----- src/wind_sample_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// wind_sample_statistics_unit
// Wind pulse sample store with period extremes and window mean / deviation.
// ----------------------------------------------------------------------------
// Clear, push and extremes query: the request is latched, executed into the
// staged result, then published. Statistics query: two memory walks at one
// sample a cycle, two bit-serial divisions and a bit-serial root.
// One request in work at a time; a new one is taken while the last result
// waits in the output register. Reset (rst_ni low, async) empties the store
// via its fill count, clears the extremes and sets speed_scale to 65536.
module wind_sample_statistics_unit #(
  parameter int unsigned SAMPLE_DEPTH       = wss_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned NUM_PERIODS        = wss_pkg::NUM_PERIODS_DEF,
  parameter int unsigned SAMPLES_PER_PERIOD = wss_pkg::SAMPLES_PER_PERIOD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wss_in_if.sink      in_i,
  wss_out_if.source   out_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wss_pkg::cmd_t cmd;
  wss_pkg::sts_t sts;
  wss_pkg::req_t req;
  wss_pkg::res_t res;

  logic [wss_pkg::SCALE_W-1:0] scale_q;

  // speed_scale is the only register; byte address 0, paddr[2] picks the slot
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(scale_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= wss_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      scale_q <= pwdata[wss_pkg::SCALE_W-1:0];
    end
  end

  // request payload into the datapath latch
  always_comb begin
    req.op             = in_i.op;
    req.sample         = in_i.sample;
    req.period         = in_i.period;
    req.offset         = in_i.offset;
    req.length         = in_i.length;
    req.use_given_mean = in_i.use_given_mean;
    req.given_mean     = in_i.given_mean;
  end

  wss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wss_datapath #(
    .SAMPLE_DEPTH       (SAMPLE_DEPTH),
    .NUM_PERIODS        (NUM_PERIODS),
    .SAMPLES_PER_PERIOD (SAMPLES_PER_PERIOD)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_i         (req),
    .speed_scale_i (scale_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_res_o     (res)
  );

  assign out_o.status     = res.status;
  assign out_o.max_value  = res.max_value;
  assign out_o.min_value  = res.min_value;
  assign out_o.mean_speed = res.mean_speed;
  assign out_o.std_speed  = res.std_speed;

endmodule
